// ----- hdl/tzc_pkg.sv -----
// shared types and constants of the four-zone tone curve core
package tzc_pkg;

    localparam int VAL_W     = 8;
    localparam int GAIN_W    = 8;
    localparam int NUM_REGS  = 4;
    localparam int LUT_DEPTH = 256;
    localparam int IDX_W     = 3;

    // floor division by the zone scale through a reciprocal, corrected afterwards
    localparam logic [14:0] DIVISOR   = 15'd25500;
    localparam logic [17:0] RECIP_M   = 18'd168431;
    localparam logic [7:0]  ZONE_SPAN = 8'd255;

    typedef enum logic [IDX_W-1:0] {
        REG_SHADOW    = 3'd0,
        REG_DARK      = 3'd1,
        REG_LIGHT     = 3'd2,
        REG_HIGHLIGHT = 3'd3
    } t_reg_idx;

    typedef logic signed [GAIN_W-1:0] t_gain;
    typedef t_gain t_gain_arr [NUM_REGS];

    typedef struct packed {
        logic             we;
        logic [VAL_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } t_lut_wr;

endpackage

// ----- hdl/tzc_ram.sv -----
// generic single-write, single-read ram with registered read data
module tzc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tzc_curve_build.sv -----
// pipelined sweep that computes the tone curve table from the zone gains
module tzc_curve_build (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tzc_pkg::t_gain_arr i_gain,
    output tzc_pkg::t_lut_wr   o_wr,
    output logic               o_busy
);
    import tzc_pkg::*;

    logic                     r_run;
    logic [VAL_W-1:0]         r_cnt;

    logic                     r_v1, r_v2, r_v3, r_v4;
    logic [VAL_W-1:0]         r_i1, r_i2, r_i3, r_i4;
    logic [13:0]              r_p1;
    logic signed [GAIN_W-1:0] r_g1;
    logic signed [21:0]       r_n2;
    logic signed [21:0]       r_n3;
    logic signed [7:0]        r_q3;
    logic signed [7:0]        r_q4;
    logic signed [17:0]       r_rem4;

    logic [1:0]               n_zone;
    logic [9:0]               n_u_ext;
    logic [VAL_W-1:0]         n_u;
    logic [VAL_W-1:0]         n_w;
    logic [15:0]              n_p;
    logic signed [22:0]       n_num;
    logic signed [40:0]       n_prod;
    logic signed [22:0]       n_qd;
    logic signed [22:0]       n_rem;
    logic signed [8:0]        n_q;
    logic signed [9:0]        n_val;
    logic [VAL_W-1:0]         n_out;

    // zone offset and parabola base
    always_comb begin
        n_zone  = r_cnt[VAL_W-1:VAL_W-2];
        n_u_ext = {r_cnt, 2'b00} - (10'(n_zone) * 10'(ZONE_SPAN));
        n_u     = n_u_ext[VAL_W-1:0];
        n_w     = ZONE_SPAN - n_u;
        n_p     = 16'(n_u) * 16'(n_w);
    end

    assign n_num  = r_g1 * $signed({1'b0, r_p1});
    assign n_prod = r_n2 * $signed({1'b0, RECIP_M});
    assign n_qd   = r_q3 * $signed({1'b0, DIVISOR});
    assign n_rem  = {r_n3[21], r_n3} - n_qd;

    // quotient correction, add and saturate
    always_comb begin
        priority if (r_rem4 < 18'sd0) begin
            n_q = {r_q4[7], r_q4} - 9'sd1;
        end else if (r_rem4 >= $signed({3'b000, DIVISOR})) begin
            n_q = {r_q4[7], r_q4} + 9'sd1;
        end else begin
            n_q = {r_q4[7], r_q4};
        end
        n_val = $signed({2'b00, r_i4}) + {n_q[8], n_q};
        priority if (n_val < 10'sd0) begin
            n_out = '0;
        end else if (n_val > 10'sd255) begin
            n_out = '1;
        end else begin
            n_out = n_val[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b1;
            r_cnt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
        end else begin
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == VAL_W'(LUT_DEPTH - 1)) begin
                    r_run <= 1'b0;
                end
            end
            r_v1 <= r_run;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_i1   <= r_cnt;
        r_p1   <= n_p[13:0];
        r_g1   <= i_gain[n_zone];
        r_i2   <= r_i1;
        r_n2   <= n_num[21:0];
        r_i3   <= r_i2;
        r_n3   <= r_n2;
        r_q3   <= n_prod[39:32];
        r_i4   <= r_i3;
        r_q4   <= r_q3;
        r_rem4 <= n_rem[17:0];
    end

    assign o_wr.we   = r_v4;
    assign o_wr.addr = r_i4;
    assign o_wr.data = n_out;
    assign o_busy    = r_run | r_v1 | r_v2 | r_v3 | r_v4;

endmodule

// ----- hdl/tzc_lookup.sv -----
// per-channel table reads with an output register for the mapped word
module tzc_lookup #(
    parameter int CHANNELS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tzc_pkg::t_lut_wr                    i_wr,
    input  logic                                i_accept,
    input  logic [tzc_pkg::VAL_W*CHANNELS-1:0]  i_data,
    output logic                                o_can_take,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [tzc_pkg::VAL_W*CHANNELS-1:0]  o_m_tdata
);
    import tzc_pkg::*;

    logic                        r_a_vld;
    logic                        r_o_vld;
    logic [VAL_W*CHANNELS-1:0]   r_o_data;
    logic [VAL_W*CHANNELS-1:0]   n_rd;
    logic                        n_a_move;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        tzc_ram #(
            .WIDTH (VAL_W),
            .DEPTH (LUT_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_wr.we),
            .i_waddr (i_wr.addr),
            .i_wdata (i_wr.data),
            .i_re    (i_accept),
            .i_raddr (i_data[c*VAL_W +: VAL_W]),
            .o_rdata (n_rd[c*VAL_W +: VAL_W])
        );
    end

    assign n_a_move   = r_a_vld & (~r_o_vld | i_m_tready);
    assign o_can_take = ~r_a_vld | n_a_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_accept) begin
                r_a_vld <= 1'b1;
            end else if (n_a_move) begin
                r_a_vld <= 1'b0;
            end
            if (n_a_move) begin
                r_o_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_o_vld <= 1'b0;
            end
        end
        if (n_a_move) begin
            r_o_data <= n_rd;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;

endmodule

// ----- hdl/four_zone_tone_curve_core.sv -----
// top level of the four-zone tone curve core
// an accepted word passes the table read register, then the output register
// one pixel per clock unless stalled, set by the single read port of each table
// reset and every gain write start a rebuild of the 256-entry curve table,
// one entry a cycle through a pipeline; ready stays low until the last write
// gain registers reset to zero, so the first table is the identity curve
module four_zone_tone_curve_core #(
    parameter int CHANNELS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tzc_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [tzc_pkg::GAIN_W-1:0]          i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // chan0_in, chan1_in, ... one byte each from the lowest bit up
    input  logic [tzc_pkg::VAL_W*CHANNELS-1:0]  i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // chan0_out, chan1_out, ... one byte each from the lowest bit up
    output logic [tzc_pkg::VAL_W*CHANNELS-1:0]  o_m_axis_tdata
);
    import tzc_pkg::*;

    t_gain_arr r_gain;
    t_lut_wr   n_wr;
    logic      n_cfg_hit;
    logic      n_busy;
    logic      n_can_take;
    logic      n_accept;

    always_comb begin
        unique case (i_cfg_idx)
            REG_SHADOW, REG_DARK, REG_LIGHT, REG_HIGHLIGHT: n_cfg_hit = i_cfg_we;
            default:                                        n_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_REGS; g++) begin
                r_gain[g] <= '0;
            end
        end else if (n_cfg_hit) begin
            r_gain[i_cfg_idx[1:0]] <= $signed(i_cfg_data);
        end
    end

    tzc_curve_build u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_cfg_hit),
        .i_gain  (r_gain),
        .o_wr    (n_wr),
        .o_busy  (n_busy)
    );

    assign o_s_axis_tready = n_can_take & ~n_busy & ~n_cfg_hit;
    assign n_accept        = i_s_axis_tvalid & o_s_axis_tready;

    tzc_lookup #(
        .CHANNELS (CHANNELS)
    ) u_lookup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (n_wr),
        .i_accept   (n_accept),
        .i_data     (i_s_axis_tdata),
        .o_can_take (n_can_take),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule
